>>> design/bpt_pkg.sv
// Shared types and constants for the polygon bin point test.
// Holds register indexes, shape codes and fixed field widths.
// No dependencies.
package bpt_pkg;

	// Twice-area output width and the packed result bus width
	localparam int AREA_W      = 33;
	localparam int OUT_TDATA_W = ((1 + AREA_W + 7) / 8) * 8;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_VCOUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_V0X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_V0Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_V1X    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_V1Y    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_V2X    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_V2Y    = 3'd6;

	// Vertex counts that select a shape
	localparam int VCOUNT_W = 2;
	localparam logic [VCOUNT_W-1:0] VCOUNT_RECT = 2'd2;
	localparam logic [VCOUNT_W-1:0] VCOUNT_TRI  = 2'd3;

	typedef enum logic [1:0] {
		SHAPE_EMPTY,
		SHAPE_RECT,
		SHAPE_TRI
	} shape_t;

	// Per-stage load enables of the pipeline
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
		logic en_s4;
	} pipe_en_t;

endpackage

>>> design/bpt_prep.sv
// Stage 1 of the point test: coordinate differences, shape decode, box test.
// Depends on bpt_pkg.
module bpt_prep #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                          clk,
	input  bpt_pkg::pipe_en_t             pipe_en,
	input  logic [bpt_pkg::VCOUNT_W-1:0]  vertex_count,
	input  logic signed [COORD_WIDTH-1:0] vert0_x,
	input  logic signed [COORD_WIDTH-1:0] vert0_y,
	input  logic signed [COORD_WIDTH-1:0] vert1_x,
	input  logic signed [COORD_WIDTH-1:0] vert1_y,
	input  logic signed [COORD_WIDTH-1:0] vert2_x,
	input  logic signed [COORD_WIDTH-1:0] vert2_y,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	output bpt_pkg::shape_t               shape_s1,
	output logic                          rect_in_s1,
	output logic signed [COORD_WIDTH:0]   dx_s1,
	output logic signed [COORD_WIDTH:0]   dy_s1,
	output logic signed [COORD_WIDTH:0]   a1_s1,
	output logic signed [COORD_WIDTH:0]   b1_s1,
	output logic signed [COORD_WIDTH:0]   a2_s1,
	output logic signed [COORD_WIDTH:0]   b2_s1,
	output logic signed [COORD_WIDTH:0]   e1_s1,
	output logic signed [COORD_WIDTH:0]   f1_s1,
	output logic signed [COORD_WIDTH:0]   f2_s1
);

	localparam int DW = COORD_WIDTH + 1;

	logic signed [COORD_WIDTH-1:0] xlo, xhi, ylo, yhi;
	logic                          box_in;
	bpt_pkg::shape_t               shape;

	function automatic logic signed [DW-1:0] sub_ext(
		input logic signed [COORD_WIDTH-1:0] a,
		input logic signed [COORD_WIDTH-1:0] b
	);
		return $signed({a[COORD_WIDTH-1], a}) - $signed({b[COORD_WIDTH-1], b});
	endfunction

	always_comb begin
		xlo    = (vert0_x < vert1_x) ? vert0_x : vert1_x;
		xhi    = (vert0_x < vert1_x) ? vert1_x : vert0_x;
		ylo    = (vert0_y < vert1_y) ? vert0_y : vert1_y;
		yhi    = (vert0_y < vert1_y) ? vert1_y : vert0_y;
		box_in = (xlo <= point_x) && (point_x <= xhi) &&
			(ylo <= point_y) && (point_y <= yhi);
		if (vertex_count == bpt_pkg::VCOUNT_RECT) begin
			shape = bpt_pkg::SHAPE_RECT;
		end else if (vertex_count == bpt_pkg::VCOUNT_TRI) begin
			shape = bpt_pkg::SHAPE_TRI;
		end else begin
			shape = bpt_pkg::SHAPE_EMPTY;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en.en_s1) begin
			shape_s1   <= shape;
			rect_in_s1 <= box_in;
			dx_s1      <= sub_ext(point_x, vert2_x);
			dy_s1      <= sub_ext(point_y, vert2_y);
			a1_s1      <= sub_ext(vert1_y, vert2_y);
			b1_s1      <= sub_ext(vert2_x, vert1_x);
			a2_s1      <= sub_ext(vert2_y, vert0_y);
			b2_s1      <= sub_ext(vert0_x, vert2_x);
			e1_s1      <= sub_ext(vert1_x, vert0_x);
			f1_s1      <= sub_ext(vert1_y, vert0_y);
			f2_s1      <= sub_ext(vert2_x, vert0_x);
		end
	end

endmodule

>>> design/bpt_mul.sv
// Stage 2 of the point test: the seven signed products.
// Depends on bpt_pkg.
module bpt_mul #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  bpt_pkg::pipe_en_t               pipe_en,
	input  bpt_pkg::shape_t                 shape_s1,
	input  logic                            rect_in_s1,
	input  logic signed [COORD_WIDTH:0]     dx_s1,
	input  logic signed [COORD_WIDTH:0]     dy_s1,
	input  logic signed [COORD_WIDTH:0]     a1_s1,
	input  logic signed [COORD_WIDTH:0]     b1_s1,
	input  logic signed [COORD_WIDTH:0]     a2_s1,
	input  logic signed [COORD_WIDTH:0]     b2_s1,
	input  logic signed [COORD_WIDTH:0]     e1_s1,
	input  logic signed [COORD_WIDTH:0]     f1_s1,
	input  logic signed [COORD_WIDTH:0]     f2_s1,
	output bpt_pkg::shape_t                 shape_s2,
	output logic                            rect_in_s2,
	output logic signed [2*COORD_WIDTH+1:0] m1_s2,
	output logic signed [2*COORD_WIDTH+1:0] m2_s2,
	output logic signed [2*COORD_WIDTH+1:0] m3_s2,
	output logic signed [2*COORD_WIDTH+1:0] m4_s2,
	output logic signed [2*COORD_WIDTH+1:0] d1_s2,
	output logic signed [2*COORD_WIDTH+1:0] d2_s2,
	output logic signed [2*COORD_WIDTH+1:0] p_s2
);

	always_ff @(posedge clk) begin
		if (pipe_en.en_s2) begin
			shape_s2   <= shape_s1;
			rect_in_s2 <= rect_in_s1;
			m1_s2      <= a1_s1 * dx_s1;
			m2_s2      <= b1_s1 * dy_s1;
			m3_s2      <= a2_s1 * dx_s1;
			m4_s2      <= b2_s1 * dy_s1;
			d1_s2      <= e1_s1 * a2_s1;
			d2_s2      <= f1_s1 * f2_s1;
			p_s2       <= e1_s1 * f1_s1;
		end
	end

endmodule

>>> design/bpt_eval.sv
// Stages 3 and 4 of the point test: sums, sign tests, area magnitude.
// Stage 4 is the result register. Depends on bpt_pkg.
module bpt_eval #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                            clk,
	input  bpt_pkg::pipe_en_t               pipe_en,
	input  bpt_pkg::shape_t                 shape_s2,
	input  logic                            rect_in_s2,
	input  logic signed [2*COORD_WIDTH+1:0] m1_s2,
	input  logic signed [2*COORD_WIDTH+1:0] m2_s2,
	input  logic signed [2*COORD_WIDTH+1:0] m3_s2,
	input  logic signed [2*COORD_WIDTH+1:0] m4_s2,
	input  logic signed [2*COORD_WIDTH+1:0] d1_s2,
	input  logic signed [2*COORD_WIDTH+1:0] d2_s2,
	input  logic signed [2*COORD_WIDTH+1:0] p_s2,
	output logic                            inside_s4,
	output logic [bpt_pkg::AREA_W-1:0]      area_s4
);

	localparam int PW = 2 * COORD_WIDTH + 2;
	localparam int SW = PW + 1;
	localparam int XW = SW + 1;
	localparam int MW = (SW > bpt_pkg::AREA_W + 1) ? SW : bpt_pkg::AREA_W + 1;

	bpt_pkg::shape_t        shape_s3;
	logic                   rect_in_s3;
	logic signed [SW-1:0]   n1_s3, n2_s3, det_s3, asrc_s3;

	logic signed [XW-1:0]   diff;
	logic [SW-1:0]          mag;
	logic [MW-1:0]          mag_ext;
	logic                   n1_pos, n1_neg, n2_pos, n2_neg, det_pos, det_neg;
	logic                   tri_in, in_shape;
	logic [bpt_pkg::AREA_W-1:0] area;

	// Stage 3: barycentric numerators, determinant, area source
	always_ff @(posedge clk) begin
		if (pipe_en.en_s3) begin
			shape_s3   <= shape_s2;
			rect_in_s3 <= rect_in_s2;
			n1_s3      <= $signed({m1_s2[PW-1], m1_s2}) + $signed({m2_s2[PW-1], m2_s2});
			n2_s3      <= $signed({m3_s2[PW-1], m3_s2}) + $signed({m4_s2[PW-1], m4_s2});
			det_s3     <= $signed({d1_s2[PW-1], d1_s2}) - $signed({d2_s2[PW-1], d2_s2});
			if (shape_s2 == bpt_pkg::SHAPE_RECT) begin
				asrc_s3 <= $signed({p_s2, 1'b0});
			end else begin
				asrc_s3 <= $signed({d1_s2[PW-1], d1_s2}) - $signed({d2_s2[PW-1], d2_s2});
			end
		end
	end

	// Stage 4: edge test against the determinant, saturate the area
	always_comb begin
		diff    = $signed({n1_s3[SW-1], n1_s3}) + $signed({n2_s3[SW-1], n2_s3})
			- $signed({det_s3[SW-1], det_s3});
		n1_neg  = n1_s3[SW-1];
		n1_pos  = !n1_s3[SW-1] && (|n1_s3);
		n2_neg  = n2_s3[SW-1];
		n2_pos  = !n2_s3[SW-1] && (|n2_s3);
		det_neg = det_s3[SW-1];
		det_pos = !det_s3[SW-1] && (|det_s3);
		if (det_pos) begin
			tri_in = n1_pos && n2_pos && diff[XW-1];
		end else if (det_neg) begin
			tri_in = n1_neg && n2_neg && !diff[XW-1] && (|diff);
		end else begin
			tri_in = 1'b0;
		end

		mag     = asrc_s3[SW-1] ? SW'(-asrc_s3) : SW'(asrc_s3);
		mag_ext = MW'(mag);

		unique case (shape_s3)
			bpt_pkg::SHAPE_RECT: begin
				in_shape = rect_in_s3;
			end
			bpt_pkg::SHAPE_TRI: begin
				in_shape = tri_in;
			end
			default: begin
				in_shape = 1'b0;
			end
		endcase

		if (shape_s3 == bpt_pkg::SHAPE_EMPTY) begin
			area = '0;
		end else if (|mag_ext[MW-1:bpt_pkg::AREA_W]) begin
			area = '1;
		end else begin
			area = mag_ext[bpt_pkg::AREA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en.en_s4) begin
			inside_s4 <= in_shape;
			area_s4   <= area;
		end
	end

endmodule

>>> design/polygon_bin_point_test.sv
// Top level of the polygon bin point test: configuration registers,
// pipeline valid chain and stream ports. Depends on bpt_pkg, bpt_prep,
// bpt_mul and bpt_eval.
//
// Usage:
//   The bin shape is loaded through the write port (cfg_we, cfg_index,
//   cfg_data): index 0 is the vertex count (2 = rectangle from two corners,
//   3 = triangle, anything else = empty bin), indexes 1..6 are the vertex
//   coordinates x0, y0, x1, y1, x2, y2 in signed Q8.8. Write only while the
//   pipeline is drained; writes to unknown indexes are dropped.
//   Query points enter on the s_ side, one request per cycle while s_tready
//   is high, and each produces exactly one result on the m_ side: an inside
//   flag and twice the bin area (unsigned Q17.16, saturated to 33 bits).
//   Pipeline: four register stages; a request moves through stages 1 to 4
//   in order, and m_tvalid rises once it reaches stage 4.
//   Throughput: one point per cycle while m_tready is high, set by the
//   four-stage pipeline (differences, multipliers, sums, sign test); the
//   seven products run in parallel.
//   Reset zeroes the configuration registers (empty bin) and all valid bits.
//   When m_tready is low, hold the result in stage 4; each earlier stage
//   keeps advancing into a free slot, so s_tready drops only once all four
//   stages are full. No request is lost or repeated under a stall.
module polygon_bin_point_test #(
	parameter int COORD_WIDTH = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// configuration write port
	input  logic                                    cfg_we,
	input  logic [bpt_pkg::CFG_IDX_W-1:0]           cfg_index,
	input  logic [COORD_WIDTH-1:0]                  cfg_data,
	// point requests
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// s_tdata, low bit up: point_x, point_y, zero fill
	input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]      s_tdata,
	// results
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// m_tdata, low bit up: inside_res, twice_area, zero fill
	output logic [bpt_pkg::OUT_TDATA_W-1:0]         m_tdata
);

	localparam int PW = 2 * COORD_WIDTH + 2;

	// Configuration registers
	logic [bpt_pkg::VCOUNT_W-1:0]  vertex_count_q;
	logic signed [COORD_WIDTH-1:0] vert0_x_q, vert0_y_q;
	logic signed [COORD_WIDTH-1:0] vert1_x_q, vert1_y_q;
	logic signed [COORD_WIDTH-1:0] vert2_x_q, vert2_y_q;

	// Pipeline control
	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	bpt_pkg::pipe_en_t pipe_en;

	// Stage payloads
	bpt_pkg::shape_t              shape_s1, shape_s2;
	logic                         rect_in_s1, rect_in_s2;
	logic signed [COORD_WIDTH:0]  dx_s1, dy_s1, a1_s1, b1_s1, a2_s1, b2_s1;
	logic signed [COORD_WIDTH:0]  e1_s1, f1_s1, f2_s1;
	logic signed [PW-1:0]         m1_s2, m2_s2, m3_s2, m4_s2, d1_s2, d2_s2, p_s2;
	logic                         inside_s4;
	logic [bpt_pkg::AREA_W-1:0]   area_s4;

	// Write the addressed register; ignore indexes past the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q <= '0;
			vert0_x_q      <= '0;
			vert0_y_q      <= '0;
			vert1_x_q      <= '0;
			vert1_y_q      <= '0;
			vert2_x_q      <= '0;
			vert2_y_q      <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpt_pkg::REG_VCOUNT: vertex_count_q <= cfg_data[bpt_pkg::VCOUNT_W-1:0];
				bpt_pkg::REG_V0X:    vert0_x_q      <= cfg_data;
				bpt_pkg::REG_V0Y:    vert0_y_q      <= cfg_data;
				bpt_pkg::REG_V1X:    vert1_x_q      <= cfg_data;
				bpt_pkg::REG_V1Y:    vert1_y_q      <= cfg_data;
				bpt_pkg::REG_V2X:    vert2_x_q      <= cfg_data;
				bpt_pkg::REG_V2Y:    vert2_y_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// A stage loads when it is empty or when the stage after it loads;
	// stage 4 frees up when the receiver takes the result.
	always_comb begin
		pipe_en.en_s4 = !valid_s4 || m_tready;
		pipe_en.en_s3 = !valid_s3 || pipe_en.en_s4;
		pipe_en.en_s2 = !valid_s2 || pipe_en.en_s3;
		pipe_en.en_s1 = !valid_s1 || pipe_en.en_s2;
	end

	assign s_tready = pipe_en.en_s1;

	// Advance the valid bits alongside the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (pipe_en.en_s1) begin
				valid_s1 <= s_tvalid;
			end
			if (pipe_en.en_s2) begin
				valid_s2 <= valid_s1;
			end
			if (pipe_en.en_s3) begin
				valid_s3 <= valid_s2;
			end
			if (pipe_en.en_s4) begin
				valid_s4 <= valid_s3;
			end
		end
	end

	// Stage 1: differences against the vertices, rectangle bounds test
	bpt_prep #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_prep (
		.clk          (clk),
		.pipe_en      (pipe_en),
		.vertex_count (vertex_count_q),
		.vert0_x      (vert0_x_q),
		.vert0_y      (vert0_y_q),
		.vert1_x      (vert1_x_q),
		.vert1_y      (vert1_y_q),
		.vert2_x      (vert2_x_q),
		.vert2_y      (vert2_y_q),
		.point_x      ($signed(s_tdata[COORD_WIDTH-1:0])),
		.point_y      ($signed(s_tdata[2*COORD_WIDTH-1:COORD_WIDTH])),
		.shape_s1     (shape_s1),
		.rect_in_s1   (rect_in_s1),
		.dx_s1        (dx_s1),
		.dy_s1        (dy_s1),
		.a1_s1        (a1_s1),
		.b1_s1        (b1_s1),
		.a2_s1        (a2_s1),
		.b2_s1        (b2_s1),
		.e1_s1        (e1_s1),
		.f1_s1        (f1_s1),
		.f2_s1        (f2_s1)
	);

	// Stage 2: barycentric, determinant and rectangle products
	bpt_mul #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_mul (
		.clk        (clk),
		.pipe_en    (pipe_en),
		.shape_s1   (shape_s1),
		.rect_in_s1 (rect_in_s1),
		.dx_s1      (dx_s1),
		.dy_s1      (dy_s1),
		.a1_s1      (a1_s1),
		.b1_s1      (b1_s1),
		.a2_s1      (a2_s1),
		.b2_s1      (b2_s1),
		.e1_s1      (e1_s1),
		.f1_s1      (f1_s1),
		.f2_s1      (f2_s1),
		.shape_s2   (shape_s2),
		.rect_in_s2 (rect_in_s2),
		.m1_s2      (m1_s2),
		.m2_s2      (m2_s2),
		.m3_s2      (m3_s2),
		.m4_s2      (m4_s2),
		.d1_s2      (d1_s2),
		.d2_s2      (d2_s2),
		.p_s2       (p_s2)
	);

	// Stages 3 and 4: sums, strict sign tests, saturated area
	bpt_eval #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_eval (
		.clk        (clk),
		.pipe_en    (pipe_en),
		.shape_s2   (shape_s2),
		.rect_in_s2 (rect_in_s2),
		.m1_s2      (m1_s2),
		.m2_s2      (m2_s2),
		.m3_s2      (m3_s2),
		.m4_s2      (m4_s2),
		.d1_s2      (d1_s2),
		.d2_s2      (d2_s2),
		.p_s2       (p_s2),
		.inside_s4  (inside_s4),
		.area_s4    (area_s4)
	);

	assign m_tvalid = valid_s4;
	assign m_tdata  = bpt_pkg::OUT_TDATA_W'({area_s4, inside_s4});

endmodule

>>> test/polygon_bin_point_test_test.sv
// Stream testbench for polygon_bin_point_test: loads rectangle, triangle and
// empty bin shapes, streams query points and checks each inside flag and area
// against a built-in predictor. Depends on bpt_pkg and the block's RTL.
`timescale 1ns / 1ps

module polygon_bin_point_test_test;

	localparam int CW = 16;
	localparam int COORD_MIN = -32768;
	localparam int COORD_MAX = 32767;
	localparam longint AREA_MAX = (longint'(1) << bpt_pkg::AREA_W) - 1;

	// Vertex counts with no shape of their own, and the index no register uses
	localparam logic [bpt_pkg::VCOUNT_W-1:0] VCOUNT_NONE = 2'd0;
	localparam logic [bpt_pkg::VCOUNT_W-1:0] VCOUNT_ONE  = 2'd1;
	localparam logic [bpt_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	// How widely random vertices are spread
	typedef enum int {
		SPREAD_FULL,
		SPREAD_TINY,
		SPREAD_MID,
		SPREAD_EDGE
	} spread_t;

	typedef struct packed {
		logic                       hit;
		logic [bpt_pkg::AREA_W-1:0] area;
	} point_verdict_t;

	typedef struct packed {
		logic [CW-1:0] x0;
		logic [CW-1:0] y0;
		logic [CW-1:0] x1;
		logic [CW-1:0] y1;
		logic [CW-1:0] x2;
		logic [CW-1:0] y2;
	} bin_corners_t;

	logic                              clk;
	logic                              arst_n;
	logic                              cfg_we;
	logic [bpt_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [CW-1:0]                     cfg_data;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [2*CW-1:0]                   s_tdata;   // point_x, point_y
	logic                              m_tvalid;
	logic                              m_tready;
	logic [bpt_pkg::OUT_TDATA_W-1:0]   m_tdata;   // inside_res, twice_area, zero fill

	// Shadow of the bin shape as last written
	logic [bpt_pkg::VCOUNT_W-1:0] shape_count;
	bin_corners_t                 shape_now;

	point_verdict_t expected_verdicts[$];
	int             mismatch_count;

	// Idling controls shared by the stimulus and the receiver
	bit sender_idles;
	bit receiver_stalls;
	int choke_len;

	polygon_bin_point_test #(
		.COORD_WIDTH(CW)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #4 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor: exact integer geometry on the shadow shape. Products of
	// 17-bit differences fit easily in 64 bits, so no wide type is needed.
	// ------------------------------------------------------------------
	function automatic point_verdict_t bin_verdict(logic [CW-1:0] px_raw, logic [CW-1:0] py_raw);
		longint px, py, x0, y0, x1, y1, x2, y2;
		longint det, n1, n2, span;
		point_verdict_t v;
		px = longint'($signed(px_raw));
		py = longint'($signed(py_raw));
		x0 = longint'($signed(shape_now.x0));
		y0 = longint'($signed(shape_now.y0));
		x1 = longint'($signed(shape_now.x1));
		y1 = longint'($signed(shape_now.y1));
		x2 = longint'($signed(shape_now.x2));
		y2 = longint'($signed(shape_now.y2));
		v.hit = 1'b0;
		span = 0;
		if (shape_count == bpt_pkg::VCOUNT_RECT) begin
			// Inclusive bounds; corners may come in either order
			v.hit = (px >= ((x0 < x1) ? x0 : x1)) && (px <= ((x0 < x1) ? x1 : x0)) &&
				(py >= ((y0 < y1) ? y0 : y1)) && (py <= ((y0 < y1) ? y1 : y0));
			span = (x1 - x0) * (y1 - y0);
			if (span < 0)
				span = -span;
			span = 2 * span;
		end else if (shape_count == bpt_pkg::VCOUNT_TRI) begin
			// Barycentric test without division; strict bounds, sign follows det
			det = (x1 - x0) * (y2 - y0) - (y1 - y0) * (x2 - x0);
			n1 = (y1 - y2) * (px - x2) + (x2 - x1) * (py - y2);
			n2 = (y2 - y0) * (px - x2) + (x0 - x2) * (py - y2);
			if (det > 0)
				v.hit = (n1 > 0) && (n2 > 0) && (n1 + n2 < det);
			else if (det < 0)
				v.hit = (n1 < 0) && (n2 < 0) && (n1 + n2 > det);
			span = (det < 0) ? -det : det;
		end
		if (span > AREA_MAX)
			span = AREA_MAX;
		v.area = span[bpt_pkg::AREA_W-1:0];
		return v;
	endfunction

	// Mostly short idle stretches, a few long ones
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [CW-1:0] vertex_coord(spread_t spread);
		case (spread)
			SPREAD_TINY: return CW'(int'($urandom_range(0, 24)) - 12);
			SPREAD_MID:  return CW'(int'($urandom_range(0, 4095)) - 2048);
			SPREAD_EDGE: begin
				case ($urandom_range(0, 2))
					0:       return CW'(COORD_MIN);
					1:       return CW'(COORD_MAX);
					default: return '0;
				endcase
			end
			default:     return CW'($urandom);
		endcase
	endfunction

	// Random coordinate within [lo, hi] widened by a few LSBs, clamped to range
	function automatic logic [CW-1:0] coord_near(int lo, int hi);
		int a, b;
		a = (lo - 3 < COORD_MIN) ? COORD_MIN : lo - 3;
		b = (hi + 3 > COORD_MAX) ? COORD_MAX : hi + 3;
		return CW'(a + int'($urandom_range(0, b - a)));
	endfunction

	// One of the shape's own vertex coordinates, or a range extreme
	function automatic logic [CW-1:0] corner_coord(bit pick_y);
		case ($urandom_range(0, 4))
			0:       return pick_y ? shape_now.y0 : shape_now.x0;
			1:       return pick_y ? shape_now.y1 : shape_now.x1;
			2:       return pick_y ? shape_now.y2 : shape_now.x2;
			3:       return CW'(COORD_MIN);
			default: return CW'(COORD_MAX);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Configuration. Callers only load a shape once the pipeline is empty.
	// cfg_we stays high across back-to-back writes and drops at the end.
	// ------------------------------------------------------------------
	task automatic put_reg(input logic [bpt_pkg::CFG_IDX_W-1:0] idx,
			input logic [CW-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_shape(input logic [CW-1:0] count_word, input bin_corners_t c,
			input bit stray);
		// A write to the unused index must leave every register alone
		if (stray)
			put_reg(REG_UNUSED, CW'($urandom));
		put_reg(bpt_pkg::REG_VCOUNT, count_word);
		put_reg(bpt_pkg::REG_V0X, c.x0);
		put_reg(bpt_pkg::REG_V0Y, c.y0);
		put_reg(bpt_pkg::REG_V1X, c.x1);
		put_reg(bpt_pkg::REG_V1Y, c.y1);
		put_reg(bpt_pkg::REG_V2X, c.x2);
		put_reg(bpt_pkg::REG_V2Y, c.y2);
		cfg_we <= 1'b0;
		shape_count = count_word[bpt_pkg::VCOUNT_W-1:0];
		shape_now = c;
	endtask

	// ------------------------------------------------------------------
	// Send one point request. Entered and left right after a rising edge;
	// s_tvalid is only lowered during a gap, so a back-to-back request keeps
	// it high. s_tready is sampled at the falling edge, where it is stable.
	// ------------------------------------------------------------------
	task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py);
		int gap;
		bit took;
		point_verdict_t want;
		gap = sender_idles ? idle_span() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			s_tdata <= $urandom;
			repeat (gap) @(posedge clk);
		end
		want = bin_verdict(px, py);
		s_tvalid <= 1'b1;
		s_tdata <= {py, px};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		expected_verdicts.push_back(want);
	endtask

	// Drop valid, wait for every expected result, then let the pipeline settle
	task automatic await_results();
		s_tvalid <= 1'b0;
		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Out of reset the bin is empty; then vertex count one, also empty
	task automatic test_empty_bin();
		bin_corners_t c;
		send_point('0, '0);
		send_point(CW'(COORD_MIN), CW'(COORD_MIN));
		send_point(CW'(COORD_MAX), CW'(COORD_MAX));
		await_results();
		c = {16'h0100, 16'hFF00, 16'h0200, 16'h0300, 16'hFE00, 16'h0000};
		load_shape({14'h2AAA, VCOUNT_ONE}, c, 1'b0);
		send_point(16'h0000, 16'h0000);
		await_results();
	endtask

	// Rectangle with swapped corners, loaded with high junk on the count word
	// and a stray write; then the full coordinate range for the largest area
	task automatic test_rectangle();
		bin_corners_t c;
		c = {16'h0300, 16'hFF00, 16'hFE00, 16'h0400, 16'h7FFF, 16'h8000};
		load_shape({14'h3FFF, bpt_pkg::VCOUNT_RECT}, c, 1'b1);
		send_point(16'h0300, 16'h0400);   // corner, bounds inclusive
		send_point(16'hFE00, 16'hFF00);   // opposite corner
		send_point(16'h0301, 16'h0000);   // one LSB right of the box
		send_point(16'h0000, 16'hFEFF);   // one LSB below the box
		send_point(16'h0000, 16'h0000);
		await_results();
		c = {16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000};
		load_shape({14'h0000, bpt_pkg::VCOUNT_RECT}, c, 1'b0);
		send_point(16'h8000, 16'h7FFF);
		send_point(16'h7FFF, 16'h8000);
		await_results();
	endtask

	// Triangles of both windings, a degenerate one and one spanning the range
	task automatic test_triangle();
		bin_corners_t c;
		c = {16'h0000, 16'h0000, 16'h0400, 16'h0000, 16'h0000, 16'h0400};
		load_shape({14'h0000, bpt_pkg::VCOUNT_TRI}, c, 1'b0);
		send_point(16'h0100, 16'h0100);   // interior
		send_point(16'h0000, 16'h0000);   // on a vertex, bounds strict
		send_point(16'h0200, 16'h0000);   // on an edge
		send_point(16'h0200, 16'h0200);   // on the hypotenuse
		send_point(16'h01FF, 16'h0200);   // one LSB inside the hypotenuse
		await_results();
		// Clockwise winding: negative determinant
		c = {16'h0000, 16'h0000, 16'h0000, 16'h0400, 16'h0400, 16'h0000};
		load_shape({14'h0000, bpt_pkg::VCOUNT_TRI}, c, 1'b0);
		send_point(16'h0100, 16'h0100);
		send_point(16'h0300, 16'h0300);
		await_results();
		// Collinear vertices: degenerate, outside with zero area
		c = {16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0200, 16'h0200};
		load_shape({14'h0000, bpt_pkg::VCOUNT_TRI}, c, 1'b0);
		send_point(16'h0100, 16'h0100);
		await_results();
		c = {16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF};
		load_shape({14'h0000, bpt_pkg::VCOUNT_TRI}, c, 1'b0);
		send_point(16'h0000, 16'h0000);
		send_point(16'h7FFF, 16'h7FFF);
		await_results();
	endtask

	// Random shapes, each followed by a burst of points mostly around the shape
	task automatic test_random_shapes();
		bin_corners_t c;
		logic [bpt_pkg::VCOUNT_W-1:0] cnt;
		spread_t spread;
		int phase, k, points, r, xlo, xhi, ylo, yhi;
		for (phase = 0; phase < 28; phase++) begin
			// Every fourth phase runs with no idling on either side
			sender_idles = (phase % 4 != 3);
			receiver_stalls = (phase % 4 != 3);
			r = $urandom_range(0, 9);
			if (r == 0)
				cnt = $urandom_range(0, 1) ? VCOUNT_ONE : VCOUNT_NONE;
			else if (r < 5)
				cnt = bpt_pkg::VCOUNT_RECT;
			else
				cnt = bpt_pkg::VCOUNT_TRI;
			spread = spread_t'($urandom_range(0, 3));
			c.x0 = vertex_coord(spread);
			c.y0 = vertex_coord(spread);
			c.x1 = vertex_coord(spread);
			c.y1 = vertex_coord(spread);
			c.x2 = vertex_coord(spread);
			c.y2 = vertex_coord(spread);
			load_shape({14'($urandom), cnt}, c, $urandom_range(0, 3) == 0);

			// Bounding box of the vertices that define the shape
			xlo = $signed(c.x0);
			xhi = xlo;
			ylo = $signed(c.y0);
			yhi = ylo;
			if ($signed(c.x1) < xlo) xlo = $signed(c.x1);
			if ($signed(c.x1) > xhi) xhi = $signed(c.x1);
			if ($signed(c.y1) < ylo) ylo = $signed(c.y1);
			if ($signed(c.y1) > yhi) yhi = $signed(c.y1);
			if (cnt == bpt_pkg::VCOUNT_TRI) begin
				if ($signed(c.x2) < xlo) xlo = $signed(c.x2);
				if ($signed(c.x2) > xhi) xhi = $signed(c.x2);
				if ($signed(c.y2) < ylo) ylo = $signed(c.y2);
				if ($signed(c.y2) > yhi) yhi = $signed(c.y2);
			end

			points = $urandom_range(40, 64);
			for (k = 0; k < points; k++) begin
				r = $urandom_range(0, 9);
				if (r < 6)
					send_point(coord_near(xlo, xhi), coord_near(ylo, yhi));
				else if (r < 9)
					send_point(CW'($urandom), CW'($urandom));
				else
					send_point(corner_coord(1'b0), corner_coord(1'b1));
			end
			await_results();
		end
	endtask

	// Hold the receiver off while requests keep coming, so the pipeline fills
	// and s_tready drops; then release and drain
	task automatic test_backpressure();
		bin_corners_t c;
		int k;
		c.x0 = vertex_coord(SPREAD_TINY);
		c.y0 = vertex_coord(SPREAD_TINY);
		c.x1 = vertex_coord(SPREAD_TINY);
		c.y1 = vertex_coord(SPREAD_TINY);
		c.x2 = vertex_coord(SPREAD_TINY);
		c.y2 = vertex_coord(SPREAD_TINY);
		load_shape({14'h0000, bpt_pkg::VCOUNT_TRI}, c, 1'b0);
		sender_idles = 1'b0;
		receiver_stalls = 1'b1;
		choke_len = 96;
		for (k = 0; k < 48; k++)
			send_point(coord_near(-12, 12), coord_near(-12, 12));
		await_results();
	endtask

	// ------------------------------------------------------------------
	// Receiver: owns m_tready. Each pass makes one assignment to m_tready
	// and ends on a rising edge. A requested hold-off is counted out here.
	// ------------------------------------------------------------------
	initial begin
		int len;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			len = (receiver_stalls && $urandom_range(0, 2) == 0) ? idle_span() : 0;
			if (choke_len > 0) begin
				m_tready <= 1'b0;
				repeat (choke_len) @(posedge clk);
				choke_len = 0;
			end else if (len > 0) begin
				m_tready <= 1'b0;
				repeat (len) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result check. Both m_tvalid and m_tready are stable at the falling
	// edge, so a handshake seen here completes at the next rising edge.
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		point_verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_verdicts.size() == 0) begin
				$error("unexpected result: inside_res=%0b twice_area=%0d",
					m_tdata[0], m_tdata[bpt_pkg::AREA_W:1]);
				mismatch_count++;
			end else begin
				want = expected_verdicts.pop_front();
				if (m_tdata[0] !== want.hit) begin
					$error("inside_res: expected %0b, actual %0b", want.hit, m_tdata[0]);
					mismatch_count++;
				end
				if (m_tdata[bpt_pkg::AREA_W:1] !== want.area) begin
					$error("twice_area: expected %0d, actual %0d", want.area,
						m_tdata[bpt_pkg::AREA_W:1]);
					mismatch_count++;
				end
			end
		end
	end

	// Hard stop well past the slowest legal run
	initial begin
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ------------------------------------------------------------------
	// Main sequence: reset once, then the tests in turn
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bpt_pkg::REG_VCOUNT;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		mismatch_count = 0;
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		choke_len = 0;
		// Shadow matches the reset state: empty bin, all vertices at zero
		shape_count = VCOUNT_NONE;
		shape_now = '0;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_bin();
		test_rectangle();
		test_triangle();
		test_random_shapes();
		test_backpressure();

		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> filelist.f
design/bpt_pkg.sv
design/bpt_prep.sv
design/bpt_mul.sv
design/bpt_eval.sv
design/polygon_bin_point_test.sv
test/polygon_bin_point_test_test.sv
